// ===== rtl/wms_pkg.sv =====
// ----------------------------------------------------------------------------
// wms_pkg
// Shared constants, codes and the angle table of the waypoint motion sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package wms_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int IDX_W        = $clog2(MAX_POINTS);
	localparam int PTR_W        = IDX_W + 1;
	localparam int CORDIC_STEPS = 16;
	localparam int ROOT_STEPS   = 16;
	localparam int ITER_N       = (CORDIC_STEPS > ROOT_STEPS) ? CORDIC_STEPS : ROOT_STEPS;
	localparam int CNT_W        = $clog2(ITER_N);

	// Configuration register indexes.
	localparam logic [2:0] REG_MAP_WIDTH = 3'd0;
	localparam logic [2:0] REG_MIN_TURN  = 3'd1;
	localparam logic [2:0] REG_STOP_DIST = 3'd2;
	localparam logic [2:0] REG_RES_DIST  = 3'd3;
	localparam logic [2:0] REG_START_DLY = 3'd4;
	localparam logic [2:0] REG_MATCH_LIM = 3'd5;
	localparam logic [2:0] REG_POINT_CNT = 3'd6;

	// Motor commands.
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_DISABLE = 3'd1;
	localparam logic [2:0] CMD_TURN    = 3'd2;
	localparam logic [2:0] CMD_DRIVE   = 3'd3;
	localparam logic [2:0] CMD_STOP    = 3'd4;
	localparam logic [2:0] CMD_RESUME  = 3'd5;

	// Run states.
	localparam logic [2:0] RUN_CORD   = 3'd0;
	localparam logic [2:0] RUN_DELAY  = 3'd1;
	localparam logic [2:0] RUN_ACTIVE = 3'd2;
	localparam logic [2:0] RUN_PAUSED = 3'd3;
	localparam logic [2:0] RUN_DONE   = 3'd4;

	// Segment phases.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TURN  = 2'd1;
	localparam logic [1:0] PH_DRIVE = 2'd2;
	localparam logic [1:0] PH_WAIT  = 2'd3;

	// Item kinds carried in tuser.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// CORDIC angle table in 1/65536 turn.
	function automatic logic [15:0] atan_lut(input logic [4:0] i);
		logic [15:0] a;
		case (i)
			5'd0:    a = 16'd8192;
			5'd1:    a = 16'd4836;
			5'd2:    a = 16'd2555;
			5'd3:    a = 16'd1297;
			5'd4:    a = 16'd651;
			5'd5:    a = 16'd326;
			5'd6:    a = 16'd163;
			5'd7:    a = 16'd81;
			5'd8:    a = 16'd41;
			5'd9:    a = 16'd20;
			5'd10:   a = 16'd10;
			5'd11:   a = 16'd5;
			5'd12:   a = 16'd3;
			5'd13:   a = 16'd1;
			5'd14:   a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/waypoint_motion_sequencer.sv =====
// ----------------------------------------------------------------------------
// waypoint_motion_sequencer
// Runs a waypoint match for a differential-drive robot, one request at a time.
// ----------------------------------------------------------------------------
// A load request writes the waypoint memory and is answered; a tick updates the
// sequencer, and a cord pull also reads the first waypoint for its heading. A
// tick that starts a segment skips each zero-length segment and runs the
// shared 16-step CORDIC and square-root loop on registered reads of the
// waypoint memory. One request is in flight at a time. Reset clears all
// control state; the waypoint memory is not reset.
`default_nettype none

module waypoint_motion_sequencer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// time_us[31:0] pull_cord[32] team_yellow[33] echo_valid[34] echo_mm[46:35]
	// motor_busy[47] point_index[53:48] point_x[66:54] point_y[79:67]
	// point_heading[95:80] point_wait_ms[111:96]
	input  wire logic [111:0] s_tdata,
	// command[0]
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// motor_command[2:0] motor_amount[18:3] run_state[21:19] segment_phase[23:22]
	// segment_number[30:24] obstacle_blocked[31] hold_torque[32] zero[39:33]
	output logic [39:0]       m_tdata
);

	localparam int IW = wms_pkg::IDX_W;
	localparam int PW = wms_pkg::PTR_W;
	localparam int CW = wms_pkg::CNT_W;

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_TICK     = 13'b0000000000010,
		S_HEAD     = 13'b0000000000100,
		S_WAIT_RD  = 13'b0000000001000,
		S_WAIT_CHK = 13'b0000000010000,
		S_SEG      = 13'b0000000100000,
		S_SEG_A    = 13'b0000001000000,
		S_SEG_B    = 13'b0000010000000,
		S_SQ1      = 13'b0000100000000,
		S_SQ2      = 13'b0001000000000,
		S_CALC     = 13'b0010000000000,
		S_DECIDE   = 13'b0100000000000,
		S_EMIT     = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration.
	logic [12:0] map_width_q;
	logic [14:0] min_turn_q;
	logic [11:0] stop_dist_q, res_dist_q;
	logic [31:0] launch_wait_q, match_limit_q;
	logic [6:0]  point_count_q;

	// Sequencer state.
	logic [2:0]    run_q, cmd_q;
	logic [1:0]    phase_q;
	logic [PW-1:0] ptr_q;
	logic [15:0]   est_q, target_q, amt_q;
	logic [13:0]   seglen_q;
	logic [31:0]   start_dl_q, phase_dl_q, match_dl_q;
	logic          armed_q, over_q, team_q, blocked_q, hold_q, from_start_q;

	// Latched tick fields.
	logic [31:0] now_q;
	logic        pull_q, yellow_q, ev_q, busy_q;
	logic [11:0] echo_q;

	// Waypoint memory.
	logic [63:0]   wp_mem [wms_pkg::MAX_POINTS];
	logic [63:0]   rdata_q;
	logic [IW-1:0] raddr;
	logic          wr_en;
	logic [63:0]   wr_data;

	// Segment arithmetic.
	logic signed [14:0] ax_q, ay_q, dx_q, dy_q, fx, fy, ddx, ddy;
	logic signed [29:0] dxw, dyw;
	logic [30:0]        rem_q, root_q, bit_q, trial;
	logic signed [26:0] cx_q, cy_q, xs, ys, x0;
	logic [15:0]        cz_q;
	logic [CW-1:0]      cnt_q;
	logic [15:0]        rd_head, rd_wait;

	logic          accept, tick_done, reached_match, reached_start, reached_phase, mo_now;
	logic          blk_next, echo_ok;
	logic [31:0]   match_gap, start_gap, phase_gap;
	logic [PW-1:0] used;
	logic [PW:0]   ptr_next1;
	logic [15:0]   tgt, dh;
	logic [16:0]   adh;
	logic [30:0]   root_r;
	logic [13:0]   len_sat;
	logic [31:0]   wait_dl;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = accept && (s_tuser == wms_pkg::KIND_LOAD);
	assign wr_data  = {6'd0, s_tdata[111:96], s_tdata[95:80], s_tdata[79:67], s_tdata[66:54]};

	assign used      = (point_count_q > 7'(wms_pkg::MAX_POINTS)) ?
		PW'(wms_pkg::MAX_POINTS) : PW'(point_count_q);
	assign ptr_next1 = {1'b0, ptr_q} + 1'b1;

	always_comb begin
		case (state_q)
			S_TICK:  raddr = '0;
			S_SEG_A: raddr = ptr_next1[IW-1:0];
			default: raddr = ptr_q[IW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wp_mem[s_tdata[48 +: IW]] <= wr_data;
		end
		rdata_q <= wp_mem[raddr];
	end

	// Team mirroring of a fetched waypoint.
	assign fx      = team_q ? {2'b00, rdata_q[12:0]} :
		$signed({2'b00, map_width_q}) - $signed({2'b00, rdata_q[12:0]});
	assign fy      = {2'b00, rdata_q[25:13]};
	assign rd_head = team_q ? rdata_q[41:26] : 16'd32768 - rdata_q[41:26];
	assign rd_wait = rdata_q[57:42];
	assign ddx     = fx - ax_q;
	assign ddy     = fy - ay_q;
	assign wait_dl = now_q + 32'(rd_wait) * 32'd1000;

	// Deadlines compare in wrapping time.
	assign match_gap     = now_q - match_dl_q;
	assign start_gap     = now_q - start_dl_q;
	assign phase_gap     = now_q - phase_dl_q;
	assign reached_match = !match_gap[31];
	assign reached_start = !start_gap[31];
	assign reached_phase = !phase_gap[31];
	assign mo_now        = over_q || (armed_q && reached_match);

	assign echo_ok  = ev_q && (echo_q != 12'd0);
	assign blk_next = !echo_ok ? blocked_q :
		(echo_q <= stop_dist_q) ? 1'b1 :
		(echo_q >= res_dist_q) ? 1'b0 : blocked_q;
	assign tick_done = (phase_q == wms_pkg::PH_WAIT) ? reached_phase :
		((phase_q == wms_pkg::PH_TURN) || (phase_q == wms_pkg::PH_DRIVE)) ? !busy_q : 1'b0;

	// CORDIC and square-root step.
	assign xs    = cx_q >>> cnt_q;
	assign ys    = cy_q >>> cnt_q;
	assign x0    = 27'(dx_q) <<< 8;
	assign trial = root_q + bit_q;
	assign dxw   = 30'(dx_q);
	assign dyw   = 30'(dy_q);

	// Segment decision.
	assign tgt     = (dy_q == 15'sd0) ? ((dx_q < 0) ? 16'd32768 : 16'd0) :
		(dx_q == 15'sd0) ? ((dy_q > 0) ? 16'd16384 : 16'd49152) : cz_q;
	assign dh      = tgt - est_q;
	assign adh     = dh[15] ? 17'd0 - {1'b1, dh} : {1'b0, dh};
	assign root_r  = (rem_q > root_q) ? root_q + 1'b1 : root_q;
	assign len_sat = (root_r > 31'd16383) ? 14'd16383 : root_r[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			map_width_q   <= 13'd3000;
			min_turn_q    <= 15'd364;
			stop_dist_q   <= 12'd150;
			res_dist_q    <= 12'd250;
			launch_wait_q <= 32'd0;
			match_limit_q <= 32'd100000000;
			point_count_q <= 7'd0;
			run_q         <= wms_pkg::RUN_CORD;
			phase_q       <= wms_pkg::PH_IDLE;
			cmd_q         <= wms_pkg::CMD_NONE;
			amt_q         <= '0;
			ptr_q         <= '0;
			est_q         <= '0;
			target_q      <= '0;
			seglen_q      <= '0;
			start_dl_q    <= '0;
			phase_dl_q    <= '0;
			match_dl_q    <= '0;
			armed_q       <= 1'b0;
			over_q        <= 1'b0;
			team_q        <= 1'b0;
			blocked_q     <= 1'b0;
			hold_q        <= 1'b0;
			from_start_q  <= 1'b0;
			m_tvalid      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wms_pkg::REG_MAP_WIDTH: map_width_q   <= cfg_data[12:0];
					wms_pkg::REG_MIN_TURN:  min_turn_q    <= cfg_data[14:0];
					wms_pkg::REG_STOP_DIST: stop_dist_q   <= cfg_data[11:0];
					wms_pkg::REG_RES_DIST:  res_dist_q    <= cfg_data[11:0];
					wms_pkg::REG_START_DLY: launch_wait_q <= cfg_data;
					wms_pkg::REG_MATCH_LIM: match_limit_q <= cfg_data;
					wms_pkg::REG_POINT_CNT: point_count_q <= cfg_data[6:0];
					default: ;
				endcase
			end

			if (m_tvalid && m_tready && state_q != S_EMIT) begin
				m_tvalid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= wms_pkg::CMD_NONE;
						amt_q    <= '0;
						now_q    <= s_tdata[31:0];
						pull_q   <= s_tdata[32];
						yellow_q <= s_tdata[33];
						ev_q     <= s_tdata[34];
						echo_q   <= s_tdata[46:35];
						busy_q   <= s_tdata[47];
						state_q  <= (s_tuser == wms_pkg::KIND_LOAD) ? S_EMIT : S_TICK;
					end
				end
				S_TICK: begin
					state_q <= S_EMIT;
					if (mo_now) begin
						if (!over_q) begin
							run_q <= wms_pkg::RUN_DONE;
						end
						over_q <= 1'b1;
						cmd_q  <= wms_pkg::CMD_DISABLE;
					end else begin
						blocked_q <= blk_next;
						case (run_q)
							wms_pkg::RUN_CORD: begin
								team_q <= yellow_q;
								cmd_q  <= wms_pkg::CMD_DISABLE;
								if (pull_q) begin
									ptr_q      <= '0;
									phase_dl_q <= '0;
									target_q   <= '0;
									phase_q    <= wms_pkg::PH_IDLE;
									seglen_q   <= '0;
									start_dl_q <= now_q + launch_wait_q;
									armed_q    <= 1'b1;
									match_dl_q <= now_q + match_limit_q;
									run_q      <= wms_pkg::RUN_DELAY;
									est_q      <= '0;
									if (used != '0) begin
										state_q <= S_HEAD;
									end
								end
							end
							wms_pkg::RUN_DELAY: begin
								cmd_q <= wms_pkg::CMD_DISABLE;
								if (reached_start) begin
									from_start_q <= 1'b1;
									state_q      <= S_WAIT_RD;
								end
							end
							wms_pkg::RUN_ACTIVE: begin
								if (blk_next && phase_q == wms_pkg::PH_DRIVE) begin
									cmd_q  <= wms_pkg::CMD_STOP;
									run_q  <= wms_pkg::RUN_PAUSED;
									hold_q <= 1'b1;
								end else begin
									hold_q       <= 1'b0;
									from_start_q <= 1'b0;
									if (tick_done) begin
										case (phase_q)
											wms_pkg::PH_TURN: begin
												est_q   <= target_q;
												phase_q <= wms_pkg::PH_DRIVE;
												cmd_q   <= wms_pkg::CMD_DRIVE;
												amt_q   <= {2'b00, seglen_q};
											end
											wms_pkg::PH_DRIVE: begin
												ptr_q   <= ptr_next1[PW-1:0];
												state_q <= S_WAIT_RD;
											end
											default: state_q <= S_SEG;
										endcase
									end
								end
							end
							wms_pkg::RUN_PAUSED: begin
								if (!blk_next) begin
									cmd_q  <= wms_pkg::CMD_RESUME;
									run_q  <= wms_pkg::RUN_ACTIVE;
									hold_q <= 1'b0;
								end
							end
							default: cmd_q <= wms_pkg::CMD_DISABLE;
						endcase
					end
				end
				S_HEAD: begin
					est_q   <= rd_head;
					state_q <= S_EMIT;
				end
				S_WAIT_RD: begin
					state_q <= (ptr_q >= used) ? S_SEG : S_WAIT_CHK;
				end
				S_WAIT_CHK: begin
					if (rd_wait == 16'd0) begin
						state_q <= S_SEG;
					end else begin
						phase_dl_q <= wait_dl;
						phase_q    <= wms_pkg::PH_WAIT;
						cmd_q      <= wms_pkg::CMD_STOP;
						amt_q      <= '0;
						if (from_start_q) begin
							run_q <= wms_pkg::RUN_ACTIVE;
						end
						state_q <= S_EMIT;
					end
				end
				S_SEG: begin
					if (ptr_next1 < {1'b0, used}) begin
						state_q <= S_SEG_A;
					end else begin
						// No segment left: the run is over.
						run_q <= wms_pkg::RUN_DONE;
						if (!from_start_q) begin
							cmd_q   <= wms_pkg::CMD_STOP;
							amt_q   <= '0;
							phase_q <= wms_pkg::PH_IDLE;
						end
						state_q <= S_EMIT;
					end
				end
				S_SEG_A: begin
					ax_q    <= fx;
					ay_q    <= fy;
					state_q <= S_SEG_B;
				end
				S_SEG_B: begin
					dx_q <= ddx;
					dy_q <= ddy;
					if (ddx == 15'sd0 && ddy == 15'sd0) begin
						ptr_q   <= ptr_next1[PW-1:0];
						state_q <= S_SEG;
					end else begin
						state_q <= S_SQ1;
					end
				end
				S_SQ1: begin
					rem_q <= 31'($unsigned(dxw * dxw));
					if (dx_q < 0) begin
						cx_q <= -x0;
						cy_q <= -(27'(dy_q) <<< 8);
						cz_q <= 16'd32768;
					end else begin
						cx_q <= x0;
						cy_q <= 27'(dy_q) <<< 8;
						cz_q <= 16'd0;
					end
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					rem_q   <= rem_q + 31'($unsigned(dyw * dyw));
					root_q  <= '0;
					bit_q   <= 31'h40000000;
					cnt_q   <= '0;
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (32'(cnt_q) < wms_pkg::CORDIC_STEPS) begin
						if (cy_q > 0) begin
							cx_q <= cx_q + ys;
							cy_q <= cy_q - xs;
							cz_q <= cz_q + wms_pkg::atan_lut(5'(cnt_q));
						end else begin
							cx_q <= cx_q - ys;
							cy_q <= cy_q + xs;
							cz_q <= cz_q - wms_pkg::atan_lut(5'(cnt_q));
						end
					end
					if (32'(cnt_q) < wms_pkg::ROOT_STEPS) begin
						if (rem_q >= trial) begin
							rem_q  <= rem_q - trial;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == wms_pkg::ITER_N - 1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					target_q <= tgt;
					seglen_q <= len_sat;
					if (adh >= {2'b00, min_turn_q}) begin
						phase_q <= wms_pkg::PH_TURN;
						cmd_q   <= wms_pkg::CMD_TURN;
						amt_q   <= dh;
					end else begin
						est_q   <= tgt;
						phase_q <= wms_pkg::PH_DRIVE;
						cmd_q   <= wms_pkg::CMD_DRIVE;
						amt_q   <= {2'b00, len_sat};
					end
					if (from_start_q) begin
						run_q <= wms_pkg::RUN_ACTIVE;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {7'd0, hold_q, blocked_q, ptr_q, phase_q, run_q, amt_q, cmd_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
